// File: hw/rtl/sfd_pkg.sv
// Shared types and constants for the signed fractional divider.
// No dependencies; imported by signed_fractional_divider_unit.
package sfd_pkg;

	localparam int IN_W              = 32;
	localparam int OUT_W             = 38;
	localparam int FRAC_BITS_DEFAULT = 6;

	typedef struct packed {
		logic signed [IN_W-1:0] dividend;
		logic signed [IN_W-1:0] divisor;
	} div_in_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] quotient_fixed;
		logic                    div_by_zero;
	} div_out_t;

endpackage

// File: hw/rtl/signed_fractional_divider_unit.sv
// Pipeline: one magnitude stage, one restoring step per quotient bit, one sign/saturate stage.
// Throughput: one transaction per cycle; the whole pipeline freezes while a finished
// result is stalled at the output register.
// Reset (arst_n low, asynchronous) clears all stage valid bits; data registers keep
// whatever they hold.
// Depends on sfd_pkg.
module signed_fractional_divider_unit #(
	parameter int FRACTION_BITS = sfd_pkg::FRAC_BITS_DEFAULT
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  sfd_pkg::div_in_t  req_data,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output sfd_pkg::div_out_t rsp_data
);
	import sfd_pkg::*;

	localparam int TOTAL = IN_W + FRACTION_BITS;
	localparam int QW    = (TOTAL > OUT_W) ? TOTAL : OUT_W;
	localparam logic [QW-1:0] POS_LIM = QW'({1'b0, {(OUT_W-1){1'b1}}});
	localparam logic [QW-1:0] NEG_LIM = QW'({1'b1, {(OUT_W-1){1'b0}}});

	logic advance;

	// index 0 is the magnitude stage, index k+1 follows restoring step k
	logic [IN_W-1:0]  rem_s [0:TOTAL];
	logic [IN_W-1:0]  num_s [0:TOTAL];
	logic [IN_W-1:0]  den_s [0:TOTAL];
	logic [TOTAL-1:0] quo_s [0:TOTAL];
	logic             neg_s [0:TOTAL];
	logic             dz_s  [0:TOTAL];
	logic             vld_s [0:TOTAL];

	logic     rsp_valid_q;
	div_out_t rsp_data_q;

	logic [IN_W-1:0] mag_a;
	logic [IN_W-1:0] mag_b;

	assign advance   = !rsp_valid_q || !rsp_stall;
	assign req_stall = !advance;
	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_data_q;

	// -2^31 negates to 0x80000000, which is its exact magnitude
	assign mag_a = req_data.dividend[IN_W-1] ? (~req_data.dividend + 1'b1) : req_data.dividend;
	assign mag_b = req_data.divisor[IN_W-1] ? (~req_data.divisor + 1'b1) : req_data.divisor;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= TOTAL; k++) begin
				vld_s[k] <= 1'b0;
			end
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			vld_s[0] <= req_valid;
			for (int k = 1; k <= TOTAL; k++) begin
				vld_s[k] <= vld_s[k-1];
			end
			rsp_valid_q <= vld_s[TOTAL];
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rem_s[0] <= '0;
			num_s[0] <= mag_a;
			den_s[0] <= mag_b;
			quo_s[0] <= '0;
			neg_s[0] <= req_data.dividend[IN_W-1] ^ req_data.divisor[IN_W-1];
			dz_s[0]  <= (mag_b == '0);
		end
	end

	for (genvar k = 0; k < TOTAL; k++) begin : g_step
		logic [IN_W:0]   trial;
		logic [IN_W+1:0] diff;
		logic            ge;

		// numerator bits run out after the integer steps; zeros shift in for the fraction
		assign trial = {rem_s[k], num_s[k][IN_W-1]};
		assign diff  = {1'b0, trial} - {2'b00, den_s[k]};
		assign ge    = !diff[IN_W+1];

		always_ff @(posedge clk) begin
			if (advance) begin
				rem_s[k+1] <= ge ? diff[IN_W-1:0] : trial[IN_W-1:0];
				num_s[k+1] <= {num_s[k][IN_W-2:0], 1'b0};
				den_s[k+1] <= den_s[k];
				quo_s[k+1] <= {quo_s[k][TOTAL-2:0], ge};
				neg_s[k+1] <= neg_s[k];
				dz_s[k+1]  <= dz_s[k];
			end
		end
	end

	logic [QW-1:0]    q_ext;
	logic [OUT_W-1:0] q_pos;
	logic [OUT_W-1:0] q_neg;
	logic [OUT_W-1:0] q_res;

	assign q_ext = QW'(quo_s[TOTAL]);
	assign q_pos = (q_ext > POS_LIM) ? POS_LIM[OUT_W-1:0] : q_ext[OUT_W-1:0];
	assign q_neg = (q_ext > NEG_LIM) ? NEG_LIM[OUT_W-1:0] : q_ext[OUT_W-1:0];
	assign q_res = dz_s[TOTAL] ? '0 : (neg_s[TOTAL] ? (~q_neg + 1'b1) : q_pos);

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_data_q.quotient_fixed <= q_res;
			rsp_data_q.div_by_zero    <= dz_s[TOTAL];
		end
	end

`ifndef SYNTHESIS
	a_dz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.div_by_zero |-> rsp_data.quotient_fixed == '0)
		else $error("zero divisor result carries a nonzero quotient");

	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall == (rsp_valid && rsp_stall))
		else $error("input stall does not follow output backpressure");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |=> $stable(vld_s[TOTAL]) && $stable(rsp_data))
		else $error("pipeline moved while frozen");

	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		!req_stall && req_valid |=> vld_s[0])
		else $error("accepted transaction not captured in first stage");
`endif

endmodule

// File: tb/tb_signed_fractional_divider_unit.sv
// Self-checking testbench for signed_fractional_divider_unit: directed and random
// operand pairs; expected Q.6 quotients are computed in-bench and checked in order.
// Depends on sfd_pkg and the divider RTL.
module tb_signed_fractional_divider_unit;
	import sfd_pkg::*;

	localparam int     FRAC     = FRAC_BITS_DEFAULT;
	localparam int     LATENCY  = 32 + FRAC + 2;
	localparam int     N_RANDOM = 1200;
	localparam int     HOLD_LEN = 300;
	localparam int     WDOG_MAX = 5000;
	localparam longint POS_MAX  = (longint'(1) << (OUT_W - 1)) - 1;
	localparam longint NEG_MAX  = longint'(1) << (OUT_W - 1);
	localparam logic signed [31:0] MAXV = 32'sh7FFF_FFFF;

	logic     clk       = 1'b0;
	logic     arst_n    = 1'b0;
	logic     req_valid = 1'b0;
	logic     req_stall;
	div_in_t  req_data  = '0;
	logic     rsp_valid;
	logic     rsp_stall = 1'b0;
	div_out_t rsp_data;

	div_in_t  operand_q[$];
	div_out_t quotient_due[$];
	int       err_cnt    = 0;
	int       n_in       = 0;
	int       wdog       = 0;
	int       hold_left  = 0;
	int       holds_done = 0;
	bit       req_fired  = 1'b0;
	logic     quiet;

	// no random idling on either side in this window
	assign quiet = (n_in >= 600 && n_in < 800);

	signed_fractional_divider_unit #(
		.FRACTION_BITS(FRAC)
	) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_data  (req_data),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_data  (rsp_data)
	);

	always #5 clk = ~clk;

	// truncated, sign-corrected, saturated quotient scaled by 2^FRAC
	function automatic div_out_t divide_fixed(div_in_t op);
		longint   num;
		longint   den;
		longint   q;
		bit       neg;
		div_out_t r;
		num = $signed(op.dividend);
		den = $signed(op.divisor);
		r   = '0;
		if (den == 0) begin
			r.div_by_zero = 1'b1;
			return r;
		end
		neg = (num < 0) != (den < 0);
		if (num < 0) num = -num;
		if (den < 0) den = -den;
		q = (num <<< FRAC) / den;
		if (neg) begin
			if (q > NEG_MAX) q = NEG_MAX;
			r.quotient_fixed = OUT_W'(-q);
		end else begin
			if (q > POS_MAX) q = POS_MAX;
			r.quotient_fixed = OUT_W'(q);
		end
		return r;
	endfunction

	// -2^31 is kept out of the random operands: it is nudged to -2^31+1
	function automatic logic [31:0] pick_operand();
		logic [31:0] v;
		case ($urandom_range(0, 5))
			0, 1: v = $urandom;
			2: v = $urandom_range(0, 255);
			3: v = 32'd1 << $urandom_range(0, 30);
			4: v = MAXV - $urandom_range(0, 3);
			default: v = $urandom_range(1, 65535);
		endcase
		if ($urandom_range(0, 1)) v = -v;
		if (v == 32'h8000_0000) v = 32'h8000_0001;
		return v;
	endfunction

	task automatic add_op(input logic signed [31:0] a, input logic signed [31:0] b);
		div_in_t op;
		op.dividend = a;
		op.divisor  = b;
		operand_q.insert(operand_q.size(), op);
	endtask

	initial begin
		div_in_t op;
		// range extremes, sign combinations, zero operands, truncation toward zero
		add_op(MAXV, MAXV);
		add_op(MAXV, 1);
		add_op(-MAXV, 1);
		add_op(MAXV, -1);
		add_op(-MAXV, -MAXV);
		add_op(1, MAXV);
		add_op(1, -MAXV);
		add_op(-1, MAXV);
		add_op(0, 5);
		add_op(0, -5);
		add_op(5, 0);
		add_op(-5, 0);
		add_op(0, 0);
		add_op(MAXV, 0);
		add_op(-MAXV, 0);
		add_op(7, 2);
		add_op(-7, 2);
		add_op(7, -2);
		add_op(-7, -2);
		add_op(1, 3);
		add_op(-1, 3);
		add_op(100, 7);
		add_op(32'sh4000_0000, 3);
		add_op(-1, -1);
		for (int i = 0; i < N_RANDOM; i++) begin
			op.dividend = pick_operand();
			op.divisor  = pick_operand();
			case ($urandom_range(0, 19))
				0: op.divisor = '0;
				1: op.dividend = '0;
				2: op.divisor = $urandom_range(0, 1) ? op.dividend : -op.dividend;
				default: ;
			endcase
			operand_q.insert(operand_q.size(), op);
		end

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		while (operand_q.size() > 0 || req_valid) @(negedge clk);
		while (quotient_due.size() > 0) @(negedge clk);
		repeat (2 * LATENCY) @(negedge clk);
		if (err_cnt == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// sender: a stalled transaction holds its payload until accepted
	always @(negedge clk) begin
		if (arst_n && (!req_valid || req_fired)) begin
			if (operand_q.size() > 0 && (quiet || $urandom_range(0, 99) >= 25)) begin
				req_data  <= operand_q.pop_front();
				req_valid <= 1'b1;
			end else
				req_valid <= 1'b0;
		end
	end

	// receiver: random stalls plus two long hold-offs that back up the pipeline
	always @(negedge clk) begin
		if (hold_left > 0) begin
			rsp_stall <= 1'b1;
			hold_left = hold_left - 1;
		end else if (arst_n && holds_done < 2 && n_in >= 300 + 500 * holds_done) begin
			rsp_stall <= 1'b1;
			hold_left  = HOLD_LEN;
			holds_done = holds_done + 1;
		end else
			rsp_stall <= arst_n && !quiet && ($urandom_range(0, 99) < 25);
	end

	// monitor, scoreboard and watchdog
	always @(posedge clk) begin
		div_out_t want;
		req_fired = 1'b0;
		if (arst_n) begin
			req_fired = req_valid && !req_stall;
			if (req_fired) begin
				quotient_due.insert(quotient_due.size(), divide_fixed(req_data));
				n_in++;
			end
			if (rsp_valid && !rsp_stall) begin
				if (quotient_due.size() == 0) begin
					err_cnt++;
					if (err_cnt <= 10)
						$display({"unexpected transaction: ",
							"quotient_fixed=%0d div_by_zero=%0b"},
							$signed(rsp_data.quotient_fixed), rsp_data.div_by_zero);
				end else begin
					want = quotient_due.pop_front();
					if (rsp_data.quotient_fixed !== want.quotient_fixed ||
						rsp_data.div_by_zero !== want.div_by_zero) begin
						err_cnt++;
						if (err_cnt <= 10)
							$display({"mismatch: quotient_fixed exp %0d got %0d, ",
								"div_by_zero exp %0b got %0b"},
								$signed(want.quotient_fixed),
								$signed(rsp_data.quotient_fixed),
								want.div_by_zero, rsp_data.div_by_zero);
					end
				end
			end
			if (req_fired || (rsp_valid && !rsp_stall))
				wdog = 0;
			else begin
				wdog++;
				if (wdog >= WDOG_MAX) begin
					$display("Testbench completed WITH ERRORS");
					$finish;
				end
			end
		end
	end

endmodule
